/* rtl/core/bbhd_pkg.sv */
// ----------------------------------------------------------------------------
// bbhd_pkg
// Shared types and constants for the byte-budget descriptor deque.
// ----------------------------------------------------------------------------
package bbhd_pkg;

   localparam int unsigned BBHD_DEPTH_DEF       = 64;
   localparam int unsigned BBHD_HANDLE_BITS_DEF = 16;
   localparam int unsigned BBHD_LEN_BITS        = 32;
   localparam logic [31:0] BBHD_LIMIT_RESET     = 32'hFFFF_FFFF;

   // Operation carried by an input item.
   typedef enum logic [1:0] {
      OP_PUSH_TAIL = 2'd0,
      OP_PUSH_HEAD = 2'd1,
      OP_POP       = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   // Outcome reported with every result item.
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_LIMIT = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the input item and read the head entry
      logic commit;    // apply the operation and load the result register
   } bbhd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_blocked;   // result register holds an item that is not taken
   } bbhd_stat_type;

endpackage

/* rtl/core/bbhd_ctrl.sv */
// ----------------------------------------------------------------------------
// bbhd_ctrl
// Controller: accepts one item, then commits it once the result slot is free.
// ----------------------------------------------------------------------------
module bbhd_ctrl
   import bbhd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  bbhd_stat_type stat,
   output bbhd_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = CS_EXEC;
            end
         end
         CS_EXEC: begin
            // Hold the item until the previous result has left.
            cmd.commit = ~stat.out_blocked;
            if (~stat.out_blocked) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/bbhd_dpath.sv */
// ----------------------------------------------------------------------------
// bbhd_dpath
// Datapath: ring memory, head/tail pointers, counters and result register.
// ----------------------------------------------------------------------------
module bbhd_dpath
   import bbhd_pkg::*;
#(
   parameter int unsigned DEPTH       = BBHD_DEPTH_DEF,
   parameter int unsigned HANDLE_BITS = BBHD_HANDLE_BITS_DEF,
   localparam int unsigned AW = $clog2(DEPTH),
   localparam int unsigned CW = $clog2(DEPTH + 1),
   localparam int unsigned LW = BBHD_LEN_BITS
)(
   input  logic                   clock,
   input  logic                   reset,
   input  bbhd_cmd_type           cmd,
   output bbhd_stat_type          stat,
   input  logic [1:0]             in_op,
   input  logic [HANDLE_BITS-1:0] in_handle,
   input  logic [LW-1:0]          in_length,
   input  logic                   csr_wr_en,
   input  logic [LW-1:0]          csr_wr_data,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [1:0]             rsp_status,
   output logic [HANDLE_BITS-1:0] rsp_handle,
   output logic [LW-1:0]          rsp_length,
   output logic [CW-1:0]          rsp_count,
   output logic [LW-1:0]          rsp_held
);

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
   localparam int unsigned   EW        = HANDLE_BITS + LW;

   // Ring storage, each entry {length, handle}.
   logic [EW-1:0] ring_mem [DEPTH];

   op_type                 op_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [LW-1:0]          length_ff;
   logic [EW-1:0]          rd_ff;
   logic [LW-1:0]          limit_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] total_ff, total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [LW-1:0]          rsp_length_ff, rsp_length_in;

   logic [LW:0]            sum;
   logic                   limit_ok;
   logic [AW-1:0]          head_next, head_prev, tail_next;
   logic                   wr_en;
   logic [AW-1:0]          wr_slot;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [LW-1:0]          rd_length;

   assign rd_handle = rd_ff[HANDLE_BITS-1:0];
   assign rd_length = rd_ff[EW-1:HANDLE_BITS];

   // Sum formed one bit wider than the operands so that an overflow cannot pass the limit.
   assign sum       = {1'b0, total_ff} + {1'b0, length_ff};
   assign limit_ok  = sum < {1'b0, limit_ff};
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign head_prev = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      wr_en         = 1'b0;
      wr_slot       = tail_ff;
      rsp_status_in = STAT_DONE;
      rsp_handle_in = '0;
      rsp_length_in = '0;
      case (op_ff)
         OP_PUSH_TAIL, OP_PUSH_HEAD: begin
            if (!limit_ok) begin
               rsp_status_in = STAT_LIMIT;
            end else if (count_ff == FULL_CNT) begin
               rsp_status_in = STAT_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               total_in = sum[LW-1:0];
               if (op_ff == OP_PUSH_TAIL) begin
                  wr_slot = tail_ff;
                  tail_in = tail_next;
               end else begin
                  wr_slot = head_prev;
                  head_in = head_prev;
               end
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               rsp_status_in = STAT_EMPTY;
            end else begin
               rsp_handle_in = rd_handle;
               rsp_length_in = rd_length;
               head_in       = head_next;
               count_in      = count_ff - CW'(1);
               total_in      = total_ff - rd_length;
            end
         end
         default: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            total_in = '0;
         end
      endcase
   end

   assign stat.out_blocked = rsp_valid_ff & ~rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         limit_ff     <= BBHD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(in_op);
         handle_ff <= in_handle;
         length_ff <= in_length;
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_length_ff <= rsp_length_in;
      end
   end

   // Ring memory: one write port, one registered read port at the head.
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         ring_mem[wr_slot] <= {length_ff, handle_ff};
      end
      if (cmd.capture) begin
         rd_ff <= ring_mem[head_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_count  = count_ff;
   assign rsp_held   = total_ff;

endmodule

/* rtl/core/byte_budget_handle_deque_top.sv */
// ----------------------------------------------------------------------------
// byte_budget_handle_deque_top
// Double-ended descriptor queue with a byte budget.
// ----------------------------------------------------------------------------
// This block keeps up to DEPTH buffer descriptors, each a handle and a byte
// length, in a circular ring that can be pushed at either end and popped at
// the head. A push is taken only if the bytes already held plus the new
// length stay strictly below the byte limit register, and only if the ring
// has a free slot; otherwise the item is refused and nothing changes. Every
// input item produces exactly one result item that carries the outcome, the
// popped descriptor (zero unless a pop succeeded), and the entry count and
// held bytes after the operation. An item is first accepted, and the head
// entry is read from the ring memory, whose read data is registered; then
// its outcome is decided and the pointers are updated. A new item is not
// accepted until the last one has committed, and the commit waits while
// the result register holds a result that is not taken. The result register
// lets a new item be accepted while the previous result still waits. The
// byte limit resets to all ones and should be written only while the block
// is idle. The ring memory needs no clearing after reset, since an entry is
// only ever used after it was written.
// ----------------------------------------------------------------------------
module byte_budget_handle_deque_top
   import bbhd_pkg::*;
#(
   parameter int unsigned DEPTH       = BBHD_DEPTH_DEF,
   parameter int unsigned HANDLE_BITS = BBHD_HANDLE_BITS_DEF,
   localparam int unsigned CW    = $clog2(DEPTH + 1),
   localparam int unsigned IN_W  = ((HANDLE_BITS + BBHD_LEN_BITS + 7) / 8) * 8,
   localparam int unsigned OUT_W = ((HANDLE_BITS + 2 * BBHD_LEN_BITS + CW + 7) / 8) * 8
)(
   input  logic             clock,
   input  logic             reset,
   // Input item channel.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,    // op
   input  logic [IN_W-1:0]  req_tdata,    // handle, byte_length, zero pad
   // Result item channel.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [1:0]       rsp_tuser,    // status
   output logic [OUT_W-1:0] rsp_tdata,    // popped_handle, popped_length,
                                          // entry_count, held_bytes, zero pad
   // Byte limit register write port.
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   bbhd_cmd_type           cmd;
   bbhd_stat_type          stat;
   logic [HANDLE_BITS-1:0] rsp_handle;
   logic [31:0]            rsp_length;
   logic [CW-1:0]          rsp_count;
   logic [31:0]            rsp_held;

   // The controller sequences each item; the datapath holds the deque state.
   bbhd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bbhd_dpath #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_op       (req_tuser),
      .in_handle   (req_tdata[HANDLE_BITS-1:0]),
      .in_length   (req_tdata[HANDLE_BITS+31:HANDLE_BITS]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_status  (rsp_tuser),
      .rsp_handle  (rsp_handle),
      .rsp_length  (rsp_length),
      .rsp_count   (rsp_count),
      .rsp_held    (rsp_held)
   );

   // Result fields packed from the lowest bit up, zero filled to whole bytes.
   assign rsp_tdata = OUT_W'({rsp_held, rsp_count, rsp_length, rsp_handle});

endmodule

/* test/byte_budget_handle_deque_top_tb.sv */
// ----------------------------------------------------------------------------
// byte_budget_handle_deque_top_tb
// Self-checking testbench for the byte-budget descriptor deque.
// ----------------------------------------------------------------------------
// A short directed sequence covers the following cases:
//    - pop on an empty ring
//    - pushes at both ends
//    - length extremes against the byte limit, where the sum must not wrap
//    - clear, and a head push that wraps the head pointer
// Several byte limit settings follow, the extremes among them. Each setting
// runs random bursts that fill the ring, drain it or mix operations. A
// tracker class mirrors the ring, predicts one result per accepted item and
// compares every result field by field. Both channels stall at random. One
// burst holds the result side off for a long stretch, and the stimulus
// drains completely before each limit write.
// ----------------------------------------------------------------------------
module byte_budget_handle_deque_top_tb;
   import bbhd_pkg::*;

   localparam int unsigned RING_DEPTH = BBHD_DEPTH_DEF;
   localparam int unsigned IN_W       = 48;
   localparam int unsigned OUT_W      = 88;
   localparam int unsigned HOLD_OFF   = 300;

   // Burst flavors of the random stimulus.
   typedef enum int {
      BURST_FILL,
      BURST_DRAIN,
      BURST_MIX
   } burst_kind;

   // One predicted result item.
   typedef struct {
      status_type  status;
      logic [15:0] popped_handle;
      logic [31:0] popped_length;
      logic [6:0]  entry_count;
      logic [31:0] held_bytes;
   } deque_result;

   // -------------------------------------------------------------------------
   // Tracker: a mirror of the ring, its pointers and the byte limit. Each
   // accepted item is applied here and its result is queued, in order.
   // -------------------------------------------------------------------------
   class deque_tracker;
      logic [15:0] ring_handle [RING_DEPTH];
      logic [31:0] ring_length [RING_DEPTH];
      logic [5:0]  head;
      logic [5:0]  tail;
      logic [6:0]  count;
      logic [31:0] total;
      logic [31:0] limit;
      deque_result expected_results [$];
      int          errors;

      function new();
         head   = '0;
         tail   = '0;
         count  = '0;
         total  = '0;
         limit  = BBHD_LIMIT_RESET;
         errors = 0;
      endfunction

      // Applies one accepted item and queues the result it must produce.
      function void apply_op(op_type op, logic [15:0] hnd, logic [31:0] len);
         deque_result r;
         logic [32:0] sum;
         r.status        = STAT_DONE;
         r.popped_handle = '0;
         r.popped_length = '0;
         sum = {1'b0, total} + {1'b0, len};
         case (op)
            OP_PUSH_TAIL, OP_PUSH_HEAD: begin
               // The byte check wins over the slot check when both fail.
               if (!(sum < {1'b0, limit})) begin
                  r.status = STAT_LIMIT;
               end else if (count >= 7'(RING_DEPTH)) begin
                  r.status = STAT_FULL;
               end else if (op == OP_PUSH_TAIL) begin
                  ring_handle[tail] = hnd;
                  ring_length[tail] = len;
                  tail  = tail + 6'd1;
                  count = count + 7'd1;
                  total = sum[31:0];
               end else begin
                  head  = head - 6'd1;
                  ring_handle[head] = hnd;
                  ring_length[head] = len;
                  count = count + 7'd1;
                  total = sum[31:0];
               end
            end
            OP_POP: begin
               if (count == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.popped_handle = ring_handle[head];
                  r.popped_length = ring_length[head];
                  head  = head + 6'd1;
                  count = count - 7'd1;
                  total = total - r.popped_length;
               end
            end
            default: begin
               head  = '0;
               tail  = '0;
               count = '0;
               total = '0;
            end
         endcase
         r.entry_count = count;
         r.held_bytes  = total;
         expected_results.push_back(r);
      endfunction

      // Compares one result item with the oldest prediction.
      function void check_result(status_type st, logic [15:0] hnd, logic [31:0] len,
                                 logic [6:0] cnt, logic [31:0] bytes);
         deque_result e;
         if (expected_results.size() == 0) begin
            $error("result item arrived with no prediction pending");
            errors++;
            return;
         end
         e = expected_results.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            errors++;
         end
         if (hnd !== e.popped_handle) begin
            $error("popped_handle: expected %0h, actual %0h", e.popped_handle, hnd);
            errors++;
         end
         if (len !== e.popped_length) begin
            $error("popped_length: expected %0h, actual %0h", e.popped_length, len);
            errors++;
         end
         if (cnt !== e.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", e.entry_count, cnt);
            errors++;
         end
         if (bytes !== e.held_bytes) begin
            $error("held_bytes: expected %0h, actual %0h", e.held_bytes, bytes);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals. Every block input starts at a known value.
   // -------------------------------------------------------------------------
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [1:0]       req_tuser   = '0;      // op
   logic [IN_W-1:0]  req_tdata   = '0;      // handle, byte_length
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [1:0]       rsp_tuser;             // status
   logic [OUT_W-1:0] rsp_tdata;             // popped_handle, popped_length,
                                            // entry_count, held_bytes, pad
   logic             csr_wr_en   = 1'b0;
   logic [31:0]      csr_wr_data = '0;

   // When set, neither side inserts idle cycles.
   bit steady = 1'b0;
   // Set by the stimulus to ask the result side for one long hold-off.
   bit hold_req = 1'b0;

   deque_tracker tracker = new();

   byte_budget_handle_deque_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs. The slowest correct run is far below
   // this, even with the long hold-off and every item stalled on both sides.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side. It stalls at random about a quarter of the time. On request
   // it holds off for a long stretch, counted here, so that the block backs
   // up and stops taking input items.
   // -------------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_OFF;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 26);
         end
      end
   end

   // Every accepted result item is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(status_type'(rsp_tuser), rsp_tdata[15:0], rsp_tdata[47:16],
                              rsp_tdata[54:48], rsp_tdata[86:55]);
      end
   end

   // -------------------------------------------------------------------------
   // Input side. Called right after a rising edge; returns at the edge that
   // accepted the item, or after the idle gap that follows it. The tracker
   // learns of the item here, so the next item is chosen from current state.
   // -------------------------------------------------------------------------
   task automatic send_item(op_type op, logic [15:0] hnd, logic [31:0] len);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {len, hnd};
      do @(posedge clock); while (!req_tready);
      tracker.apply_op(op, hnd, len);
      if (!steady && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted result has come. Each
   // item yields a result, so the block is idle once every result has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.limit = value;
   endtask

   // Picks a byte length. Fill bursts keep lengths small so the ring itself
   // runs out of slots; otherwise some lengths sit right at the remaining
   // room, one under and one at the point of refusal.
   function automatic logic [31:0] pick_length(bit fill);
      int unsigned r;
      logic [31:0] span;
      logic [31:0] room;
      r    = $urandom_range(99);
      span = (tracker.limit >= 160) ? tracker.limit / 80 : 32'd2;
      if (fill) begin
         return (r < 5) ? 32'hFFFF_FFFF : 32'($urandom_range(0, span));
      end
      if (r < 10) begin
         return '0;
      end else if (r < 20) begin
         return (r < 14) ? 32'hFFFF_FFFF : 32'($urandom);
      end else if (r < 35 && tracker.limit > tracker.total) begin
         room = tracker.limit - tracker.total;
         return room - 32'($urandom_range(0, 1));
      end
      return 32'($urandom_range(0, span));
   endfunction

   function automatic op_type pick_op(burst_kind kind);
      int unsigned r;
      r = $urandom_range(99);
      case (kind)
         BURST_FILL: begin
            if (r < 92) return r[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL;
            return (r < 98) ? OP_POP : OP_CLEAR;
         end
         BURST_DRAIN: begin
            if (r < 80) return OP_POP;
            return (r < 98) ? (r[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL) : OP_CLEAR;
         end
         default: begin
            if (r < 55) return r[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL;
            return (r < 97) ? OP_POP : OP_CLEAR;
         end
      endcase
   endfunction

   // Random bursts under the current limit until n items have gone in.
   task automatic run_random(int n);
      int        sent;
      int        burst_len;
      burst_kind kind;
      op_type    op;
      sent = 0;
      while (sent < n) begin
         kind      = burst_kind'($urandom_range(0, 2));
         burst_len = (kind == BURST_FILL) ? $urandom_range(70, 100) : $urandom_range(20, 90);
         for (int i = 0; i < burst_len && sent < n; i++) begin
            op = pick_op(kind);
            send_item(op, 16'($urandom), pick_length(kind == BURST_FILL));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset limit of all ones.
      send_item(OP_POP,       16'h1234, 32'h0000_0007);  // pop on an empty ring
      send_item(OP_PUSH_TAIL, 16'hFFFF, 32'h0000_0000);  // zero length
      send_item(OP_PUSH_HEAD, 16'h0000, 32'hFFFF_FFFE);  // one under the limit
      send_item(OP_PUSH_TAIL, 16'h8001, 32'h0000_0000);  // still just under
      send_item(OP_PUSH_TAIL, 16'h4002, 32'h0000_0001);  // sum reaches limit
      send_item(OP_PUSH_HEAD, 16'h2003, 32'hFFFF_FFFF);  // sum must not wrap
      send_item(OP_POP,       16'h0000, 32'h0000_0000);
      send_item(OP_POP,       16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_POP,       16'h0000, 32'h0000_0000);
      send_item(OP_POP,       16'h0000, 32'h0000_0000);  // empty again
      send_item(OP_PUSH_TAIL, 16'hAAAA, 32'h5555_5555);
      send_item(OP_PUSH_HEAD, 16'h5555, 32'hAAAA_AAAA);  // refused by one byte
      send_item(OP_PUSH_HEAD, 16'h5555, 32'h2AAA_AAAA);
      send_item(OP_CLEAR,     16'hBEEF, 32'hDEAD_BEEF);  // clear a loaded ring
      send_item(OP_POP,       16'h0000, 32'h0000_0000);  // empty after clear
      send_item(OP_PUSH_HEAD, 16'h0F0F, 32'h0000_0100);  // head wraps to the top
      send_item(OP_PUSH_TAIL, 16'hF0F0, 32'h0000_0200);
      send_item(OP_PUSH_HEAD, 16'h1111, 32'h0000_0300);
      send_item(OP_POP,       16'h0000, 32'h0000_0000);
      send_item(OP_POP,       16'h0000, 32'h0000_0000);
      send_item(OP_CLEAR,     16'h0000, 32'h0000_0000);

      // A zero limit refuses every push, and a limit of one takes only
      // zero-length buffers.
      write_limit(32'h0000_0000);
      run_random(40);
      write_limit(32'h0000_0001);
      run_random(60);

      // Full range limit, with the long result hold-off at its start. The
      // request is made while the block is idle.
      write_limit(32'hFFFF_FFFF);
      hold_req = 1'b1;
      run_random(300);

      // A tight limit, run with no idle cycles on either side.
      write_limit(32'd5000);
      steady = 1'b1;
      run_random(300);
      steady = 1'b0;

      write_limit(32'($urandom));
      run_random(300);
      write_limit(32'h8000_0000);
      run_random(300);
      write_limit(32'd100_000);
      run_random(300);

      drain();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
